// ===== sv/bbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared types and constants for the byte block entropy engine.
// ----------------------------------------------------------------------------
package bbe_pkg;

  // default block capacity in bytes
  localparam int MAX_BLOCK_BYTES_DEF = 4096;
  // histogram size
  localparam int NUM_BINS = 256;
  localparam int BIN_AW = 8;
  // log2 format: integer part and fraction bits
  localparam int LOG_INT_W = 5;
  localparam int FRAC_W = 32;
  localparam int LOG_W = LOG_INT_W + FRAC_W;
  // quotient bits of the final division
  localparam int QUOT_W = 18;
  // result saturation
  localparam logic [15:0] H_MAX_Q12 = 16'd32768;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] entropy_q12;
    logic [12:0] byte_count;
    logic        overflow;
  } out_item_t;

endpackage

// ===== sv/byte_block_entropy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_block_entropy
// Byte histogram in a 256-entry memory; on the last byte of a block the
// Shannon entropy is computed over the bins and emitted as Q4.12.
// ----------------------------------------------------------------------------
// Each byte is a memory read, then an increment and write back.
// A last byte adds a finalize pass: each bin is read and checked, and each
// nonzero bin gets the iterative log2 and product; then come log2(N) and
// the 18-step divider, and the result strobe follows.
// After reset a clearing pass zeroes all 256 bins, busy high.
// The result is shown for one cycle; the receiver cannot stall.
module byte_block_entropy #(
  parameter int MAX_BLOCK_BYTES = bbe_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  bbe_pkg::in_item_t  in_item_i,
  output logic               res_valid_o,
  output bbe_pkg::out_item_t res_item_o
);

  localparam int CW = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int AW = CW + bbe_pkg::LOG_W;
  localparam int XW = AW + 1;
  localparam int DVW = CW + 20;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_UPD  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_LOG  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_SUB  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;

  logic [3:0]                state_q, state_d;
  logic [bbe_pkg::BIN_AW-1:0] idx_q, idx_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic                      ovf_q, ovf_d;
  logic                      is_n_q, is_n_d;
  logic [7:0]                byte_q, byte_d;
  logic                      last_q, last_d;
  logic                      counted_q, counted_d;
  logic [CW-1:0]             cval_q, cval_d;
  logic [AW-1:0]             acc_q, acc_d;
  logic [AW-1:0]             tot_q, tot_d;
  logic [CW+31:0]            mul_lo_q;
  logic [CW+4:0]             mul_hi_q;
  logic                      res_valid_q, res_valid_d;
  bbe_pkg::out_item_t        res_q, res_d;

  logic                      ram_we;
  logic [bbe_pkg::BIN_AW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0]             ram_wdata, ram_rdata;

  logic                      log_start;
  logic [CW-1:0]             log_x;
  logic                      log_done;
  logic [bbe_pkg::LOG_INT_W-1:0] log_exp;
  logic [bbe_pkg::FRAC_W-1:0] log_frac;

  logic                      div_start;
  logic [XW-1:0]             div_num;
  logic [DVW-1:0]            div_den;
  logic                      div_done;
  logic [bbe_pkg::QUOT_W-1:0] div_quot;

  logic [AW-1:0]             prod_sum;
  logic [AW-1:0]             diff;
  logic                      accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  bbe_hist_ram #(
    .DW (CW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bbe_log2 #(
    .CW (CW)
  ) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .exp_o   (log_exp),
    .frac_o  (log_frac)
  );

  bbe_div #(
    .XW (XW),
    .DW (DVW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // product of count and its log2, and the final difference
  assign prod_sum = (AW'(mul_hi_q) << bbe_pkg::FRAC_W) + AW'(mul_lo_q);
  assign diff     = (tot_q > acc_q) ? (tot_q - acc_q) : '0;
  assign div_num  = XW'(diff) + (XW'(cnt_q) << 19);
  assign div_den  = DVW'(cnt_q) << 20;

  // read address: incoming byte while idle, sweep index otherwise
  assign ram_raddr = (state_q == S_IDLE) ? in_item_i.byte_value : idx_q;

  // control sequence
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    is_n_d      = is_n_q;
    byte_d      = byte_q;
    last_d      = last_q;
    counted_d   = counted_q;
    cval_d      = cval_q;
    acc_d       = acc_q;
    tot_d       = tot_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = '0;
    log_start   = 1'b0;
    log_x       = cnt_q;
    div_start   = 1'b0;
    case (state_q)
      S_CLR: begin
        ram_we = 1'b1;
        idx_d  = idx_q + 8'd1;
        if (idx_q == 8'(bbe_pkg::NUM_BINS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          byte_d    = in_item_i.byte_value;
          last_d    = in_item_i.last_byte;
          counted_d = (cnt_q < CW'(MAX_BLOCK_BYTES));
          if (cnt_q < CW'(MAX_BLOCK_BYTES)) begin
            cnt_d = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        ram_we    = counted_q;
        ram_waddr = byte_q;
        ram_wdata = ram_rdata + CW'(1);
        if (last_q) begin
          idx_d   = '0;
          is_n_d  = 1'b0;
          acc_d   = '0;
          state_d = S_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        // clear the bin as it is read
        ram_we = 1'b1;
        if (ram_rdata != '0) begin
          log_x     = ram_rdata;
          log_start = 1'b1;
          cval_d    = ram_rdata;
          state_d   = S_LOG;
        end else if (idx_q == 8'(bbe_pkg::NUM_BINS - 1)) begin
          log_start = 1'b1;
          cval_d    = cnt_q;
          is_n_d    = 1'b1;
          state_d   = S_LOG;
        end else begin
          idx_d   = idx_q + 8'd1;
          state_d = S_RD;
        end
      end
      S_LOG: begin
        if (log_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (is_n_q) begin
          tot_d   = prod_sum;
          state_d = S_SUB;
        end else begin
          acc_d = acc_q + prod_sum;
          if (idx_q == 8'(bbe_pkg::NUM_BINS - 1)) begin
            log_start = 1'b1;
            cval_d    = cnt_q;
            is_n_d    = 1'b1;
            state_d   = S_LOG;
          end else begin
            idx_d   = idx_q + 8'd1;
            state_d = S_RD;
          end
        end
      end
      S_SUB: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          res_valid_d = 1'b1;
          res_d.entropy_q12 = (div_quot > bbe_pkg::QUOT_W'(bbe_pkg::H_MAX_Q12)) ?
                              bbe_pkg::H_MAX_Q12 : div_quot[15:0];
          res_d.byte_count  = 13'(cnt_q);
          res_d.overflow    = ovf_q;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      idx_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      is_n_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      is_n_q      <= is_n_d;
      res_valid_q <= res_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    last_q    <= last_d;
    counted_q <= counted_d;
    cval_q    <= cval_d;
    acc_q     <= acc_d;
    tot_q     <= tot_d;
    res_q     <= res_d;
    mul_lo_q  <= (CW + 32)'(cval_q) * (CW + 32)'(log_frac);
    mul_hi_q  <= (CW + 5)'(cval_q) * (CW + 5)'(log_exp);
  end

  assign res_valid_o = res_valid_q;
  assign res_item_o  = res_q;

`ifndef NO_ASSERTIONS
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("two results in consecutive cycles");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_item_o.entropy_q12 <= bbe_pkg::H_MAX_Q12))
    else $error("entropy above saturation");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("not busy after an accepted item");
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_BLOCK_BYTES))
    else $error("byte count beyond capacity");
`endif

endmodule

// ===== sv/bbe_hist_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_hist_ram
// Histogram memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bbe_hist_ram #(
  parameter int DW = 13
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [bbe_pkg::BIN_AW-1:0] waddr_i,
  input  logic [DW-1:0]             wdata_i,
  input  logic [bbe_pkg::BIN_AW-1:0] raddr_i,
  output logic [DW-1:0]             rdata_o
);

  logic [DW-1:0] mem [bbe_pkg::NUM_BINS];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/bbe_log2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_log2
// Iterative log2 in Q.32: leading one gives the integer part, then one
// fraction bit per cycle by squaring the mantissa.
// ----------------------------------------------------------------------------
module bbe_log2 #(
  parameter int CW = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [CW-1:0]                 x_i,
  output logic                          done_o,
  output logic [bbe_pkg::LOG_INT_W-1:0] exp_o,
  output logic [bbe_pkg::FRAC_W-1:0]    frac_o
);

  logic                          run_q, run_d;
  logic [5:0]                    step_q, step_d;
  logic                          done_q, done_d;
  logic [31:0]                   m_q, m_d;
  logic [bbe_pkg::FRAC_W-1:0]    frac_q, frac_d;
  logic [bbe_pkg::LOG_INT_W-1:0] exp_q, exp_d;
  logic [bbe_pkg::LOG_INT_W-1:0] lead;
  logic [63:0]                   sq;
  logic [32:0]                   sq_s;

  // leading one position
  always_comb begin
    lead = '0;
    for (int i = 0; i < CW; i++) begin
      if (x_i[i]) begin
        lead = bbe_pkg::LOG_INT_W'(i);
      end
    end
  end

  // one squaring step
  assign sq   = 64'(m_q) * 64'(m_q);
  assign sq_s = sq[63:31];

  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    done_d = 1'b0;
    m_d    = m_q;
    frac_d = frac_q;
    exp_d  = exp_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      exp_d  = lead;
      frac_d = '0;
      m_d    = 32'(x_i) << (5'd31 - 5'(lead));
    end else if (run_q) begin
      frac_d = {frac_q[bbe_pkg::FRAC_W-2:0], sq_s[32]};
      m_d    = sq_s[32] ? sq_s[32:1] : sq_s[31:0];
      step_d = step_q + 6'd1;
      if (step_q == 6'(bbe_pkg::FRAC_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    frac_q <= frac_d;
    exp_q  <= exp_d;
  end

  assign done_o = done_q;
  assign exp_o  = exp_q;
  assign frac_o = frac_q;

endmodule

// ===== sv/bbe_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbe_div
// Restoring divider, one quotient bit per cycle, fixed quotient width.
// ----------------------------------------------------------------------------
module bbe_div #(
  parameter int XW = 51,
  parameter int DW = 33
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [XW-1:0]              num_i,
  input  logic [DW-1:0]              den_i,
  output logic                       done_o,
  output logic [bbe_pkg::QUOT_W-1:0] quot_o
);

  logic                       run_q, run_d;
  logic                       done_q, done_d;
  logic [4:0]                 step_q, step_d;
  logic [XW-1:0]              rem_q, rem_d;
  logic [XW-1:0]              dsh_q, dsh_d;
  logic [bbe_pkg::QUOT_W-1:0] quot_q, quot_d;
  logic                       ge;

  assign ge = (rem_q >= dsh_q);

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      rem_d  = num_i;
      dsh_d  = XW'(den_i) << (bbe_pkg::QUOT_W - 1);
      quot_d = '0;
    end else if (run_q) begin
      if (ge) begin
        rem_d = rem_q - dsh_q;
      end
      quot_d = {quot_q[bbe_pkg::QUOT_W-2:0], ge};
      dsh_d  = dsh_q >> 1;
      step_d = step_q + 5'd1;
      if (step_q == 5'(bbe_pkg::QUOT_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== test/entropy_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entropy_checker
// Watches the byte and result channels of byte_block_entropy, builds the
// block histogram on accepted bytes, predicts the Q4.12 entropy on each
// last byte and compares every result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module entropy_checker #(
  parameter int MAX_BLOCK_BYTES = bbe_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  bbe_pkg::in_item_t  in_item_i,
  input  logic               res_valid_i,
  input  bbe_pkg::out_item_t res_item_i,
  output int                 errors_o,
  output int                 pending_o
);
  import bbe_pkg::*;

  int unsigned        hist [NUM_BINS];
  int unsigned        bytes_in_block;
  logic               dropped;
  out_item_t          expected_blocks [$];

  // log2 in Q.32: highest set bit, then fraction bits by repeated squaring
  function automatic logic [63:0] log2_q32(input int unsigned x);
    int unsigned e;
    logic [63:0] m;
    logic [63:0] frac;
    e = 0;
    frac = '0;
    if (x == 0) return '0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    m = 64'(x) << (31 - e);
    for (int i = 0; i < FRAC_W; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    return (64'(e) << 32) | frac;
  endfunction

  // entropy of the current histogram, rounded half up, saturated
  function automatic logic [15:0] block_entropy();
    logic [63:0] n;
    logic [63:0] s;
    logic [63:0] total;
    logic [63:0] t;
    logic [63:0] q;
    n = 64'(bytes_in_block);
    s = '0;
    if (n == 0) return '0;
    for (int i = 0; i < NUM_BINS; i++)
      if (hist[i] != 0) s += 64'(hist[i]) * log2_q32(hist[i]);
    total = n * log2_q32(bytes_in_block);
    t = (total > s) ? total - s : '0;
    q = (t + (n << 19)) / (n << 20);
    if (q > 64'(H_MAX_Q12)) q = 64'(H_MAX_Q12);
    return q[15:0];
  endfunction

  assign pending_o = expected_blocks.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      foreach (hist[i]) hist[i] = 0;
      bytes_in_block = 0;
      dropped = 1'b0;
      errors_o <= 0;
    end else begin
      // result side: compare with the oldest prediction
      if (res_valid_i) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result %p", $time, res_item_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_blocks.pop_front();
          if (res_item_i.entropy_q12 !== want.entropy_q12 ||
              res_item_i.byte_count !== want.byte_count ||
              res_item_i.overflow !== want.overflow) begin
            $display("%0t: expected entropy %0d count %0d ovf %0b, got %0d %0d %0b",
                     $time, want.entropy_q12, want.byte_count, want.overflow,
                     res_item_i.entropy_q12, res_item_i.byte_count,
                     res_item_i.overflow);
            errors_o <= errors_o + 1;
          end
        end
      end
      // byte side: count the item, predict on the last byte
      if (start_i && !busy_i) begin
        if (bytes_in_block < MAX_BLOCK_BYTES) begin
          hist[in_item_i.byte_value]++;
          bytes_in_block++;
        end else begin
          dropped = 1'b1;
        end
        if (in_item_i.last_byte) begin
          want.entropy_q12 = block_entropy();
          want.byte_count = bytes_in_block[12:0];
          want.overflow = dropped;
          expected_blocks.push_back(want);
          foreach (hist[i]) hist[i] = 0;
          bytes_in_block = 0;
          dropped = 1'b0;
        end
      end
    end
  end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds byte blocks to byte_block_entropy: directed blocks (single byte,
// single value, two values, all values) then random blocks of mostly
// small size with random gaps; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import bbe_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      res_valid;
  out_item_t res_item;
  int        errors;
  int        pending;
  bit        gaps_on = 1'b1;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  byte_block_entropy dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_item_i(in_item), .res_valid_o(res_valid), .res_item_o(res_item)
  );

  entropy_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy),
    .in_item_i(in_item), .res_valid_i(res_valid), .res_item_i(res_item),
    .errors_o(errors), .pending_o(pending)
  );

  // present one byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    in_item.byte_value = value;
    in_item.last_byte = last;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // block of len bytes; alphabet limits the spread of byte values
  task automatic send_block(input int len, input int alphabet);
    logic [7:0] base;
    base = 8'($urandom);
    for (int i = 0; i < len; i++)
      send_byte(base + 8'($urandom_range(0, alphabet - 1)), i == len - 1);
  endtask

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int len;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes and special cases
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    repeat (4) send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    for (int i = 0; i < NUM_BINS; i++) send_byte(8'(i), i == NUM_BINS - 1);

    // hold off until every pending result is out
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);

    // random blocks, mostly small, a few with no gaps
    for (int b = 0; b < 45; b++) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0: send_block(len, 1);
        1: send_block(len, 4);
        2: send_block(len, 32);
        default: send_block(len, 256);
      endcase
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
